@@ rtl/core/svp_pkg.sv @@
package svp_pkg;

  // sample memory geometry, depth is a power of two
  localparam int MEM_DEPTH = 65536;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // fixed-point step format
  localparam int FRAC_BITS = 10;

  // field widths of the item ports
  localparam int KIND_W  = 3;
  localparam int IADDR_W = 16;
  localparam int SAMP_W  = 8;
  localparam int LEN_W   = 17;
  localparam int STEP_W  = 16;

  // derived arithmetic widths
  localparam int ACC_W   = STEP_W + 1;
  localparam int WHOLE_W = ACC_W - FRAC_BITS;
  localparam int CNT_W   = LEN_W + 1;

  localparam logic [SAMP_W-1:0] SILENCE  = SAMP_W'(128);
  localparam logic [STEP_W-1:0] UNITY    = STEP_W'(1) << FRAC_BITS;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_PLAY  = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_QUEUE = 3'd4,
    KIND_STEP  = 3'd5
  } kind_t;

  // what a tick hands to the output stage
  typedef struct packed {
    logic silent;
    logic playing;
  } tick_info_t;

endpackage

@@ rtl/core/svp_ctrl.sv @@
module svp_ctrl
  import svp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [KIND_W-1:0]  kind,
  input  logic [IADDR_W-1:0] address,
  input  logic [SAMP_W-1:0]  sample_value,
  input  logic [LEN_W-1:0]   length,
  input  logic [STEP_W-1:0]  increment,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [SAMP_W-1:0]  wr_data,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  output logic               tick_go,
  output tick_info_t         tick_info
);

  logic [ADDR_W-1:0]    ptr_r, ptr_nxt;
  logic [LEN_W-1:0]     count_r, count_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [IADDR_W-1:0]   nstart_r, nstart_nxt;
  logic [LEN_W-1:0]     nlen_r, nlen_nxt;

  logic               active;
  logic [ACC_W-1:0]   acc;
  logic [WHOLE_W-1:0] whole;
  logic [CNT_W-1:0]   diff;
  logic               ended;
  logic               same_clip;

  // phase accumulator and remaining count arithmetic
  assign active    = (count_r != '0);
  assign acc       = ACC_W'(frac_r) + ACC_W'(step_r);
  assign whole     = acc[ACC_W-1:FRAC_BITS];
  assign diff      = {1'b0, count_r} - CNT_W'(whole);
  assign ended     = diff[CNT_W-1] || (diff == '0);
  assign same_clip = active && (nstart_r == address) && (nlen_r == length);

  // memory ports: writes go straight in, ticks read at the current pointer
  assign wr_en   = accept && (kind == KIND_WRITE);
  assign wr_addr = ADDR_W'(address);
  assign wr_data = sample_value;
  assign tick_go = accept && (kind == KIND_TICK);
  assign rd_en   = tick_go && active;
  assign rd_addr = ptr_r;

  // next state per item kind
  always_comb begin
    ptr_nxt    = ptr_r;
    count_nxt  = count_r;
    frac_nxt   = frac_r;
    step_nxt   = step_r;
    nstart_nxt = nstart_r;
    nlen_nxt   = nlen_r;
    if (accept) begin
      case (kind)
        KIND_TICK: begin
          if (active) begin
            frac_nxt = acc[FRAC_BITS-1:0];
            if (ended) begin
              count_nxt = nlen_r;
              ptr_nxt   = ADDR_W'(nstart_r);
            end else begin
              count_nxt = diff[LEN_W-1:0];
              ptr_nxt   = ptr_r + ADDR_W'(whole);
            end
          end
        end
        KIND_PLAY: begin
          nlen_nxt  = '0;
          step_nxt  = UNITY;
          frac_nxt  = '0;
          ptr_nxt   = ADDR_W'(address);
          count_nxt = length;
        end
        KIND_STOP: begin
          count_nxt = '0;
        end
        KIND_QUEUE: begin
          if (!same_clip) begin
            if (!active) begin
              ptr_nxt   = ADDR_W'(address);
              count_nxt = length;
            end
            nstart_nxt = address;
            nlen_nxt   = length;
          end
        end
        KIND_STEP: begin
          step_nxt = increment;
        end
        default: begin
        end
      endcase
    end
  end

  assign tick_info.silent  = !active;
  assign tick_info.playing = (count_nxt != '0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      count_r  <= '0;
      frac_r   <= '0;
      step_r   <= UNITY;
      nstart_r <= '0;
      nlen_r   <= '0;
    end else begin
      ptr_r    <= ptr_nxt;
      count_r  <= count_nxt;
      frac_r   <= frac_nxt;
      step_r   <= step_nxt;
      nstart_r <= nstart_nxt;
      nlen_r   <= nlen_nxt;
    end
  end

endmodule

@@ rtl/core/svp_sample_mem.sv @@
module svp_sample_mem
  import svp_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SAMP_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SAMP_W-1:0] rd_data
);

  logic [SAMP_W-1:0] mem [MEM_DEPTH];
  logic [SAMP_W-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/svp_out.sv @@
module svp_out
  import svp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_go,
  input  tick_info_t        tick_info,
  input  logic [SAMP_W-1:0] rd_data,
  output logic              hold,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SAMP_W-1:0] out_sample_out,
  output logic              out_playing
);

  logic              s1_v_r, s1_v_nxt;
  tick_info_t        s1_info_r;
  logic              s1_adv;
  logic              ov_r, ov_nxt;
  logic [SAMP_W-1:0] samp_r;
  logic              play_r;

  // memory data stage moves on when the output register is free or taken
  assign s1_adv = s1_v_r && (!ov_r || !out_stall);
  assign hold   = s1_v_r && !s1_adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (tick_go) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    ov_nxt = ov_r;
    if (s1_adv) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick_go) begin
      s1_info_r <= tick_info;
    end
    if (s1_adv) begin
      samp_r <= s1_info_r.silent ? SILENCE : rd_data;
      play_r <= s1_info_r.playing;
    end
  end

  assign out_valid      = ov_r;
  assign out_sample_out = samp_r;
  assign out_playing    = play_r;

endmodule

@@ rtl/core/variable_rate_sample_player.sv @@
// Variable-rate PCM clip player. Every item is taken in one cycle and a new
// one can follow in the next; in_stall rises only while a finished tick
// result and the one behind it are both held up by out_stall. Only tick items
// produce a result: the sample (128 when silent) and whether playback is still
// running after the tick. A result passes the registered sample memory read
// and then the output register. Sample writes land in memory at once, so a
// tick right after a write already sees the new value. Play resets the step
// to unity and drops the queued clip; the queued clip reloads when the count
// runs out, which gives looping. Memory entries that were never written read
// as unknown.
module variable_rate_sample_player
  import svp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [IADDR_W-1:0] in_address,
  input  logic [SAMP_W-1:0]  in_sample_value,
  input  logic [LEN_W-1:0]   in_length,
  input  logic [STEP_W-1:0]  in_increment,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SAMP_W-1:0]  out_sample_out,
  output logic               out_playing
);

  logic              accept;
  logic              hold;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SAMP_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [SAMP_W-1:0] rd_data;
  logic              tick_go;
  tick_info_t        tick_info;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  svp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .kind         (in_kind),
    .address      (in_address),
    .sample_value (in_sample_value),
    .length       (in_length),
    .increment    (in_increment),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .tick_go      (tick_go),
    .tick_info    (tick_info)
  );

  svp_sample_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  svp_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_go        (tick_go),
    .tick_info      (tick_info),
    .rd_data        (rd_data),
    .hold           (hold),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_playing    (out_playing)
  );

endmodule

@@ rtl/core/svp_checker.sv @@
module svp_checker
  import svp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [KIND_W-1:0]  in_kind,
  input logic               out_valid,
  input logic               out_stall,
  input logic [SAMP_W-1:0]  out_sample_out,
  input logic               out_playing
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out) && $stable(out_playing))
    else $error("stalled result changed or dropped");

  // input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a tick taken with the output empty gives a valid result after the memory read register and the output register
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_TICK) && !out_valid |=> ##1 out_valid)
    else $error("tick result missing");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind variable_rate_sample_player svp_checker u_svp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_playing    (out_playing)
);
